@@ rtl/tovs_pkg.sv @@
// tovs_pkg: shared types, controller commands and exp2 fraction table
// for the triangle oscillator; no dependencies
`default_nettype none
package tovs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SHIFT,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic shift;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd89478;

    // 2^(i/16) in unsigned q.16, i = 0..16
    function automatic logic [17:0] exp2_tab(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/triangle_oscillator_voct_sync.sv @@
// triangle oscillator with v/oct pitch and hard sync
// an input beat steps through the exp2, the split 47x18 increment multiply,
// the shifter and the phase update before output valid, and no new beat is
// taken until it is done; the phase update waits while the output is full
// reset: synchronous active low; phase cleared, sample period to 89478
`default_nettype none
module triangle_oscillator_voct_sync
    import tovs_pkg::*;
#(
    parameter int FULLSCALE_VOLTS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_volt_per_octave,
    input  wire logic signed [23:0] i_fundamental_hz,
    input  wire logic signed [15:0] i_sync_level,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_triangle
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tovs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tovs_dp #(
        .FULLSCALE_VOLTS (FULLSCALE_VOLTS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_volt_per_octave (i_volt_per_octave),
        .i_fundamental_hz  (i_fundamental_hz),
        .i_sync_level      (i_sync_level),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_triangle        (o_triangle)
    );

endmodule
`default_nettype wire

@@ rtl/tovs_ctrl.sv @@
// tovs_ctrl: sequencer that steps one beat through the datapath
// depends on tovs_pkg
`default_nettype none
module tovs_ctrl
    import tovs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_SHIFT;
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = ST_UPD;
            end
            ST_UPD: begin
                // hold until the output register is free
                if (!i_stat.out_full) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tovs_dp.sv @@
// tovs_dp: exp2 pitch, increment multiplies, shifter, phase and triangle
// depends on tovs_pkg
`default_nettype none
module tovs_dp
    import tovs_pkg::*;
#(
    parameter int FULLSCALE_VOLTS = 10,
    parameter int PHASE_BITS      = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic signed [15:0] i_volt_per_octave,
    input  wire logic signed [23:0] i_fundamental_hz,
    input  wire logic signed [15:0] i_sync_level,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_triangle
);

    localparam int EW = 16 + $clog2(FULLSCALE_VOLTS + 1);
    localparam int NW = EW - 15;
    localparam int PB = PHASE_BITS;
    localparam logic [PB-1:0] HALF  = {1'b1, {(PB-1){1'b0}}};
    localparam logic [PB:0]   FULL  = {1'b1, {PB{1'b0}}};

    logic        [31:0]    r_sp;
    logic signed [15:0]    r_v;
    logic signed [23:0]    r_fund;
    logic signed [15:0]    r_sync;
    logic        [17:0]    r_m;
    logic signed [NW-1:0]  r_n;
    logic        [46:0]    r_b;
    logic        [41:0]    r_plo;
    logic        [63:0]    r_prod;
    logic        [PB-1:0]  r_mag;
    logic        [PB-1:0]  r_phase;
    logic                  r_ovalid;
    logic signed [15:0]    r_tri;

    // pitch split and exp2 of the fraction
    logic signed [EW-1:0] w_e;
    logic        [4:0]    w_idx;
    logic        [10:0]   w_r;
    logic        [17:0]   w_lo, w_hi;
    logic        [23:0]   w_ip;
    logic        [23:0]   w_fmag;
    logic        [55:0]   w_bfull;

    assign w_e     = EW'(r_v) * signed'(EW'(FULLSCALE_VOLTS));
    assign w_idx   = {1'b0, w_e[14:11]};
    assign w_r     = w_e[10:0];
    assign w_lo    = exp2_tab(w_idx);
    assign w_hi    = exp2_tab(w_idx + 5'd1);
    assign w_ip    = 24'(w_hi - w_lo) * 24'(w_r);
    assign w_fmag  = r_fund[23] ? 24'(-r_fund) : 24'(r_fund);
    assign w_bfull = 56'(w_fmag) * 56'(r_sp);

    // octave shift and saturation at half a cycle
    logic signed [7:0]  w_sh;
    logic signed [7:0]  w_nsh;
    logic        [79:0] w_wide;

    assign w_sh  = 8'(48 - PB) - 8'(r_n);
    assign w_nsh = -w_sh;

    always_comb begin
        if (w_sh >= 0) begin
            w_wide = 80'(r_prod >> w_sh[5:0]);
        end else begin
            w_wide = 80'(r_prod) << w_nsh[4:0];
        end
    end

    // phase update and triangle fold
    logic [PB-1:0] w_p;
    logic [PB:0]   w_p2;
    logic [PB:0]   w_a;
    logic [16:0]   w_t;

    always_comb begin
        if (r_fund[23]) begin
            w_p = r_phase - r_mag;
        end else begin
            w_p = r_phase + r_mag;
        end
        if (r_sync > 16'sd0) begin
            w_p = '0;
        end
    end

    assign w_p2 = {w_p, 1'b0};
    assign w_a  = w_p[PB-1] ? (w_p2 - FULL) : (FULL - w_p2);
    assign w_t  = 17'(w_a >> (PB - 16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= SAMPLE_PERIOD_RESET;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sp <= i_cfg_data;
            end
            if (i_cmd.upd) begin
                r_phase  <= w_p;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_volt_per_octave;
            r_fund <= i_fundamental_hz;
            r_sync <= i_sync_level;
        end
        if (i_cmd.mul1) begin
            r_m <= w_lo + 18'(w_ip >> 11);
            r_n <= w_e[EW-1:15];
            r_b <= 47'(w_bfull >> 8);
        end
        if (i_cmd.mul2) begin
            r_plo <= 42'(r_b[23:0]) * 42'(r_m);
        end
        if (i_cmd.mul3) begin
            r_prod <= ((64'(r_b[46:24]) * 64'(r_m)) << 24) + 64'(r_plo);
        end
        if (i_cmd.shift) begin
            r_mag <= (w_wide > 80'(HALF)) ? HALF : w_wide[PB-1:0];
        end
        if (i_cmd.upd) begin
            // peak within one output step of half a cycle saturates
            r_tri <= (w_t == 17'd0) ? 16'sh7fff : signed'(16'(17'h08000 - w_t));
        end
    end

    assign o_stat.out_full = r_ovalid && !i_ready;
    assign o_valid         = r_ovalid;
    assign o_triangle      = r_tri;

endmodule
`default_nettype wire

@@ dv/triangle_oscillator_voct_sync_checker.sv @@
// checker for the triangle oscillator: watches the input and output channels,
// predicts each triangle sample and compares; depends on nothing but the ports
`timescale 1ns / 100ps
`default_nettype none
module triangle_oscillator_voct_sync_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [31:0] i_cfg_data,
    input  wire logic               i_valid,
    input  wire logic               i_ready_in,
    input  wire logic signed [15:0] i_volt_per_octave,
    input  wire logic signed [23:0] i_fundamental_hz,
    input  wire logic signed [15:0] i_sync_level,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [15:0] i_triangle,
    output int                      o_fail_count,
    output int                      o_pending
);
    localparam int VOLTS = 10;
    localparam int PBITS = 32;

    logic [63:0] osc_phase;
    logic [31:0] period_q32;
    logic signed [15:0] tri_expected_q[$];

    function automatic logic [17:0] frac_pow2(input int i);
        logic [17:0] t [17];
        t = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
              96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
        return t[i];
    endfunction

    task automatic advance_phase(input logic signed [15:0] vo,
                                 input logic signed [23:0] fh,
                                 input logic signed [15:0] sy);
        longint e, n, sh;
        logic [63:0] eo, m, fmag, prod, mag, half, p, a;
        int f, idx, r;
        longint x, y;
        half = 64'd1 << (PBITS - 1);
        e = longint'(vo) * VOLTS;
        eo = e + (64'sd1 <<< 40);
        n = longint'(eo >> 15) - (64'sd1 <<< 25);
        f = int'(eo & 64'h7fff);
        idx = f >> 11;
        r = f & 'h7ff;
        m = frac_pow2(idx) + (((frac_pow2(idx + 1) - frac_pow2(idx)) * r) >> 11);
        fmag = (fh < 0) ? -longint'(fh) : longint'(fh);
        prod = ((fmag * period_q32) >> 8) * m;
        sh = 48 - PBITS - n;
        if (sh >= 64) mag = 0;
        else if (sh >= 0) mag = prod >> sh;
        else if (-sh >= 64) mag = (prod != 0) ? half : 0;
        else if (prod > (half >> -sh)) mag = half;
        else mag = prod << -sh;
        if (mag > half) mag = half;
        p = (fh < 0) ? osc_phase - mag : osc_phase + mag;
        p &= (64'd1 << PBITS) - 1;
        if (sy > 0) p = 0;
        osc_phase = p;
        x = longint'(p << 1) - (64'sd1 <<< PBITS);
        a = (x < 0) ? -x : x;
        y = 32768 - longint'(a >> (PBITS - 16));
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        tri_expected_q.push_back(y[15:0]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            osc_phase = 0;
            period_q32 = 32'd89478;
        end else begin
            if (i_cfg_we) period_q32 = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (tri_expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected beat triangle=%0d", i_triangle));
                else if (tri_expected_q[0] !== i_triangle)
                    report_mismatch($sformatf("triangle got %0d want %0d",
                                              i_triangle, tri_expected_q[0]));
                if (tri_expected_q.size() != 0) void'(tri_expected_q.pop_front());
            end
            if (i_valid && i_ready_in)
                advance_phase(i_volt_per_octave, i_fundamental_hz, i_sync_level);
        end
        o_pending = tri_expected_q.size();
    end
endmodule
`default_nettype wire

@@ dv/triangle_oscillator_voct_sync_tb.sv @@
// testbench top for the triangle oscillator: clock, reset, stimulus, verdict;
// depends on the rtl block and triangle_oscillator_voct_sync_checker
`timescale 1ns / 100ps
`default_nettype none
module triangle_oscillator_voct_sync_tb;
    logic i_clk, i_rst_n, i_cfg_we, i_valid, i_ready, o_ready, o_valid;
    logic [31:0] i_cfg_data;
    logic signed [15:0] i_volt_per_octave, i_sync_level, o_triangle;
    logic signed [23:0] i_fundamental_hz;
    int fail_count, pending, cycle_count;
    int send_idle_pct, recv_stall_pct;

    triangle_oscillator_voct_sync dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_volt_per_octave(i_volt_per_octave),
        .i_fundamental_hz(i_fundamental_hz), .i_sync_level(i_sync_level),
        .o_valid(o_valid), .i_ready(i_ready), .o_triangle(o_triangle)
    );

    triangle_oscillator_voct_sync_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_volt_per_octave(i_volt_per_octave),
        .i_fundamental_hz(i_fundamental_hz), .i_sync_level(i_sync_level),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_triangle(o_triangle),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("triangle_oscillator_voct_sync_tb failed");
            $finish;
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input logic signed [15:0] vo, input logic signed [23:0] fh,
                               input logic signed [15:0] sy);
        // the block takes no new beat until it is done with the last one anyway
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_volt_per_octave <= vo;
        i_fundamental_hz <= fh;
        i_sync_level <= sy;
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 1'b0;
    endtask

    task automatic write_period(input logic [31:0] v);
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // mostly audio-range pitch and frequency, some full-range noise
    task automatic random_sample();
        logic signed [15:0] vo, sy;
        logic signed [23:0] fh;
        vo = 16'($urandom);
        fh = 24'($urandom);
        sy = ($urandom_range(9) == 0) ? 16'($urandom) : -16'($urandom_range(32768));
        if ($urandom_range(3) != 0) begin
            vo = $signed(16'($urandom_range(6000))) - 16'sd3000;
            fh = $signed(24'($urandom_range(400000))) - 24'sd200000;
        end
        send_sample(vo, fh, sy);
    endtask

    initial begin
        logic [31:0] periods [5];
        cycle_count = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = 0; i_valid = 0; i_ready = 0;
        i_volt_per_octave = 0; i_fundamental_hz = 0; i_sync_level = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // extremes, zero frequency, negative frequency, sync, peak, saturation
        send_sample(16'sd0, 24'sd0, 16'sd0);
        send_sample(16'sd0, 24'sd12288000, 16'sd0);
        send_sample(16'sd0, 24'sd12288000, 16'sd0);
        send_sample(16'sh7fff, 24'sh7fffff, 16'sd0);
        send_sample(-16'sh8000, -24'sh800000, 16'sd0);
        send_sample(16'sh7fff, -24'sh800000, 16'sh8000);
        send_sample(16'sd0, 24'sd256, 16'sd1);
        send_sample(-16'sh8000, 24'sh7fffff, 16'sh7fff);
        send_sample(16'sd1234, -24'sd5000, 16'sd0);
        send_sample(16'shffff, 24'sd1, -16'sd1);
        periods = '{32'd1, 32'hffffffff, 32'd0, 32'h80000000, 32'd89478};
        for (int ph = 0; ph < 5; ph++) begin
            write_period(periods[ph]);
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 72; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 72; end
                3: begin send_idle_pct = 6; recv_stall_pct = 6; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 1) send_sample(16'sd0, 24'sd3072000, 16'sd0);
            for (int k = 0; k < 350; k++) random_sample();
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("triangle_oscillator_voct_sync_tb passed");
        else
            $display("triangle_oscillator_voct_sync_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
